@@ rtl/core/assert_macros.svh @@
// shared assertion shorthands, all sampled on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds on the same edge as the antecedent
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds on the edge after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sem_pkg.sv @@
package sem_pkg;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int SUM_W      = 21;
  localparam int RAD_W      = 16;
  localparam int REM_W      = 9;
  localparam int ROOT_W     = 8;
  localparam int SQRT_STEPS = 8;
  localparam int ROW_W      = 17;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // floor(x/3) for x up to 765 as (x*683) >> 11
  localparam int GRAY_SHIFT = 11;
  localparam int GRAY_PROD_W = 19;
  localparam logic [GRAY_PROD_W-1:0] GRAY_RECIP = 19'd683;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE   = 2'd2;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;
  localparam logic            CM_RESET = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // column*3 + row, column 0 left, row 0 top
  typedef logic [8:0][PIX_W-1:0] window_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic left_pad;
    logic right_pad;
  } item_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic left_pad;
    logic right_pad;
  } grad_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             sat;
    logic [RAD_W-1:0] radicand;
  } sqrt_in_t;

  typedef struct packed {
    logic valid;
    logic last;
    pix_t value;
  } sqrt_out_t;

endpackage

@@ rtl/core/sem_ram.sv @@
module sem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sem_window.sv @@
`include "assert_macros.svh"

module sem_window import sem_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  pix_t          in_gray,
  input  logic [CW-1:0] in_col,
  input  logic          in_row1,
  input  logic          in_row2,
  input  item_ctl_t     in_ctl,
  output window_t       win,
  output grad_ctl_t     grad_ctl
);

  logic          b_valid;
  pix_t          b_gray;
  logic [CW-1:0] b_col;
  logic          b_row1;
  logic          b_row2;
  item_ctl_t     b_ctl;
  logic          fwd;
  line_pair_t    fwd_data;
  line_pair_t    rd_data;
  line_pair_t    line_rd;
  line_pair_t    line_wr;
  pix_t          top;
  pix_t          mid;
  logic          ram_we;
  logic          c_valid;
  item_ctl_t     c_ctl;

  // both line stores share one entry per column
  sem_ram #(
    .WIDTH($bits(line_pair_t)),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (ram_we),
    .waddr(b_col),
    .wdata(line_wr),
    .re   (in_valid),
    .raddr(in_col),
    .rdata(rd_data)
  );

  assign ram_we  = adv && b_valid;
  // a write-back to the entry being read in the same cycle is forwarded
  assign line_rd = fwd ? fwd_data : rd_data;
  assign top     = b_row2 ? line_rd.upper  : '0;
  assign mid     = b_row1 ? line_rd.middle : '0;
  assign line_wr = '{upper: mid, middle: b_gray};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd     <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= in_valid;
      fwd     <= in_valid && ram_we && (in_col == b_col);
      c_valid <= b_valid && b_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_valid) begin
        b_gray   <= in_gray;
        b_col    <= in_col;
        b_row1   <= in_row1;
        b_row2   <= in_row2;
        b_ctl    <= in_ctl;
        fwd_data <= line_wr;
      end
      if (b_valid) begin
        for (int i = 0; i < 6; i++) begin
          win[i] <= win[i+3];
        end
        win[6] <= top;
        win[7] <= mid;
        win[8] <= b_gray;
        c_ctl  <= b_ctl;
      end
    end
  end

  assign grad_ctl = '{
    valid:     c_valid,
    last:      c_ctl.last,
    left_pad:  c_ctl.left_pad,
    right_pad: c_ctl.right_pad
  };

  `ASSERT_IMPLIES(a_fwd_has_item, clk, rst, fwd, b_valid, "forward flag without item in stage")
  `ASSERT_IMPLIES(a_row_flags, clk, rst, b_valid && b_row2, b_row1, "row two set without row one")

endmodule

@@ rtl/core/sem_sqrt.sv @@
module sem_sqrt import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  sqrt_in_t  in,
  output sqrt_out_t out
);

  logic [SQRT_STEPS-1:0] st_valid;
  logic [SQRT_STEPS-1:0] st_last;
  logic [SQRT_STEPS-1:0] st_sat;
  logic [RAD_W-1:0]      st_rad  [SQRT_STEPS];
  logic [REM_W-1:0]      st_rem  [SQRT_STEPS];
  logic [ROOT_W-1:0]     st_root [SQRT_STEPS];
  logic [REM_W-1:0]      rem_nxt  [SQRT_STEPS];
  logic [ROOT_W-1:0]     root_nxt [SQRT_STEPS];

  // one result bit per stage, two radicand bits brought down each time
  always_comb begin
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [RAD_W-1:0]  rad_prev;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        rem_prev  = '0;
        root_prev = '0;
        rad_prev  = in.radicand;
      end else begin
        rem_prev  = st_rem[k-1];
        root_prev = st_root[k-1];
        rad_prev  = st_rad[k-1];
      end
      rem_sh = {rem_prev, rad_prev[2*(SQRT_STEPS-1-k) +: 2]};
      trial  = {1'b0, root_prev, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt[k]  = REM_W'(rem_sh - trial);
        root_nxt[k] = {root_prev[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh[REM_W-1:0];
        root_nxt[k] = {root_prev[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (adv) begin
      st_valid <= {st_valid[SQRT_STEPS-2:0], in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_last <= {st_last[SQRT_STEPS-2:0], in.last};
      st_sat  <= {st_sat[SQRT_STEPS-2:0], in.sat};
      st_rad[0] <= in.radicand;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        st_rad[k] <= st_rad[k-1];
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
        st_rem[k]  <= rem_nxt[k];
        st_root[k] <= root_nxt[k];
      end
    end
  end

  assign out = '{
    valid: st_valid[SQRT_STEPS-1],
    last:  st_last[SQRT_STEPS-1],
    value: st_sat[SQRT_STEPS-1] ? pix_t'(8'hFF) : st_root[SQRT_STEPS-1]
  };

endmodule

@@ rtl/core/sobel_edge_magnitude_core.sv @@
// takes one pixel or flush item per cycle while the output register can move; a full
// output register with m_tready low stalls the whole pipe and s_tready
// the result for pixel (r, c) leaves once the item frame_width+1 places later is accepted
// and has passed through line-store read, window, gradients, squares, 8-stage square root, output
// synchronous active-high reset clears counters and valid bits and sets frame_width 640,
// frame_height 480, colour mode on; line stores keep their contents, row position masks them
`include "assert_macros.svh"

module sobel_edge_magnitude_core import sem_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,   // chan0, chan1, chan2
  input  logic                   s_tuser,   // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // edge_value
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int FW_EXT = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam logic [CW-1:0]     WLAST_MAX = CW'(MAX_WIDTH - 1);
  localparam logic [FW_EXT-1:0] WIDTH_MAX = FW_EXT'(MAX_WIDTH);

  // last column index, width 0 acting as 1 and wide frames clamped
  function automatic logic [CW-1:0] eff_wlast(input logic [FW_W-1:0] fw);
    logic [FW_EXT-1:0] fx;
    fx = FW_EXT'(fw);
    if (fw == '0) begin
      return '0;
    end else if (fx > WIDTH_MAX) begin
      return WLAST_MAX;
    end else begin
      return CW'(fx - FW_EXT'(1));
    end
  endfunction

  function automatic logic [FH_W-1:0] eff_height(input logic [FH_W-1:0] fh);
    return (fh == '0) ? FH_W'(1) : fh;
  endfunction

  logic [CW-1:0]    wlast;
  logic [FH_W-1:0]  h_eff;
  logic             color_mode;
  logic [CW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;

  logic             adv;
  logic             in_fire;
  pix_t             chan0;
  pix_t             chan1;
  pix_t             chan2;
  logic [9:0]       chan_sum;
  logic [GRAY_PROD_W-1:0] gray_prod;
  pix_t             gray;
  logic             in_row1;
  logic             in_row2;
  item_ctl_t        in_ctl;

  window_t          win;
  grad_ctl_t        grad_ctl;
  pix_t             z [9];
  logic [9:0]       pos_x;
  logic [9:0]       neg_x;
  logic [9:0]       pos_y;
  logic [9:0]       neg_y;

  logic                      d_valid;
  logic                      d_last;
  logic signed [GRAD_W-1:0]  gx;
  logic signed [GRAD_W-1:0]  gy;
  logic signed [2*GRAD_W-1:0] gx_sq;
  logic signed [2*GRAD_W-1:0] gy_sq;
  logic                      e_valid;
  logic                      e_last;
  logic [SQ_W-1:0]           sx;
  logic [SQ_W-1:0]           sy;
  logic [SUM_W-1:0]          sq_sum;
  sqrt_in_t                  sq_in;
  sqrt_out_t                 sq_out;

  logic out_valid;
  pix_t out_value;
  logic out_last;

  assign adv      = !out_valid || m_tready;
  assign s_tready = adv;
  assign in_fire  = s_tvalid && adv;

  assign chan0 = s_tdata[7:0];
  assign chan1 = s_tdata[15:8];
  assign chan2 = s_tdata[23:16];

  assign chan_sum  = 10'(chan0) + 10'(chan1) + 10'(chan2);
  assign gray_prod = GRAY_PROD_W'(chan_sum) * GRAY_RECIP;

  always_comb begin
    if (s_tuser == KIND_FLUSH || row_cnt >= ROW_W'(h_eff)) begin
      gray = '0;
    end else if (color_mode) begin
      gray = gray_prod[GRAY_SHIFT +: PIX_W];
    end else begin
      gray = chan0;
    end
  end

  assign in_row1          = row_cnt != '0;
  assign in_row2          = |row_cnt[ROW_W-1:1];
  assign in_ctl.emit      = in_row2 || (in_row1 && col_cnt != '0);
  assign in_ctl.last      = (row_cnt == ROW_W'(h_eff) + ROW_W'(1)) && (col_cnt == '0);
  // the window centre sits one column back, wrapping to the previous row's last column
  assign in_ctl.left_pad  = (col_cnt == '0) ? (wlast == '0) : (col_cnt == CW'(1));
  assign in_ctl.right_pad = col_cnt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wlast      <= eff_wlast(FW_RESET);
      h_eff      <= eff_height(FH_RESET);
      color_mode <= CM_RESET;
      col_cnt    <= '0;
      row_cnt    <= '0;
    end else begin
      if (in_fire) begin
        if (in_ctl.emit && in_ctl.last) begin
          col_cnt <= '0;
          row_cnt <= '0;
        end else if (col_cnt == wlast) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            wlast   <= eff_wlast(cfg_data[FW_W-1:0]);
            col_cnt <= '0;
            row_cnt <= '0;
          end
          CFG_FRAME_HEIGHT: begin
            h_eff   <= eff_height(cfg_data[FH_W-1:0]);
            col_cnt <= '0;
            row_cnt <= '0;
          end
          CFG_COLOR_MODE: begin
            color_mode <= cfg_data[0];
            col_cnt    <= '0;
            row_cnt    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  sem_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_valid(in_fire),
    .in_gray (gray),
    .in_col  (col_cnt),
    .in_row1 (in_row1),
    .in_row2 (in_row2),
    .in_ctl  (in_ctl),
    .win     (win),
    .grad_ctl(grad_ctl)
  );

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      z[i] = win[i];
    end
    if (grad_ctl.left_pad) begin
      z[0] = '0;
      z[1] = '0;
      z[2] = '0;
    end
    if (grad_ctl.right_pad) begin
      z[6] = '0;
      z[7] = '0;
      z[8] = '0;
    end
  end

  assign pos_x = 10'(z[2]) + 10'({z[5], 1'b0}) + 10'(z[8]);
  assign neg_x = 10'(z[0]) + 10'({z[3], 1'b0}) + 10'(z[6]);
  assign pos_y = 10'(z[6]) + 10'({z[7], 1'b0}) + 10'(z[8]);
  assign neg_y = 10'(z[0]) + 10'({z[1], 1'b0}) + 10'(z[2]);

  assign gx_sq = gx * gx;
  assign gy_sq = gy * gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      d_valid   <= grad_ctl.valid;
      e_valid   <= d_valid;
      out_valid <= sq_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_last <= grad_ctl.last;
      gx     <= $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
      gy     <= $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
      e_last <= d_last;
      sx     <= SQ_W'(gx_sq);
      sy     <= SQ_W'(gy_sq);
      if (sq_out.valid) begin
        out_value <= sq_out.value;
        out_last  <= sq_out.last;
      end
    end
  end

  assign sq_sum = SUM_W'(sx) + SUM_W'(sy);
  assign sq_in  = '{
    valid:    e_valid,
    last:     e_last,
    sat:      |sq_sum[SUM_W-1:RAD_W],
    radicand: sq_sum[RAD_W-1:0]
  };

  sem_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in (sq_in),
    .out(sq_out)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tlast  = out_last;

  `ASSERT_ALWAYS(a_col_bound, clk, rst, col_cnt <= wlast, "column count beyond row end")
  `ASSERT_ALWAYS(a_row_bound, clk, rst, row_cnt <= ROW_W'(h_eff) + ROW_W'(1), "row count beyond flush rows")
  `ASSERT_NEXT(a_frame_restart, clk, rst, in_fire && in_ctl.emit && in_ctl.last, row_cnt == '0 && col_cnt == '0, "frame did not restart after last result")

endmodule

@@ test/sobel_edge_magnitude_core_tb.sv @@
module sobel_edge_magnitude_core_tb import sem_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 2048;
  localparam int unsigned RANDOM_ITEMS = 820;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 40;
  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_t;

  typedef struct {
    pix_t edge_value;
    logic frame_last;
  } edge_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [23:0]            s_tdata = '0;   // chan0, chan1, chan2
  logic                   s_tuser = 1'b0; // kind
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;        // edge_value
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  sobel_edge_magnitude_core #(.MAX_WIDTH(MAX_W)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state, reset values
  pix_t            upper_row [MAX_W] = '{default: '0};
  pix_t            middle_row [MAX_W] = '{default: '0};
  pix_t            win [9] = '{default: '0};
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;
  int unsigned     results_in_frame = 0;
  logic [FW_W-1:0] cfg_width = FW_RESET;
  logic [FH_W-1:0] cfg_height = FH_RESET;
  logic            cfg_colour = CM_RESET;

  edge_result_t edge_expected [$];

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frames_done = 0;
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_request = 0;
  int unsigned cycle_count = 0;
  bit          sender_gaps = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sobel_edge_magnitude_core test failed");
    $finish;
  end

  function automatic void restart_position();
    col_pos = 0;
    row_pos = 0;
    results_in_frame = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FRAME_WIDTH:  cfg_width = data[FW_W-1:0];
      CFG_FRAME_HEIGHT: cfg_height = data[FH_W-1:0];
      CFG_COLOR_MODE:   cfg_colour = data[0];
      default:          return;
    endcase
    restart_position();
  endfunction

  // advances the window by one item and queues the edge result it completes, if any
  function automatic void sobel_predict(input logic kind, input pix_t c0, input pix_t c1,
                                        input pix_t c2);
    int unsigned w, h, c, r, g, top, mid, cc, sq, root;
    int z [9];
    int gx, gy;
    edge_result_t res;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
    h = (cfg_height == 0) ? 1 : cfg_height;
    c = col_pos;
    r = row_pos;
    g = cfg_colour ? (int'(c0) + int'(c1) + int'(c2)) / 3 : c0;
    if (kind == KIND_FLUSH || r >= h) g = 0;
    top = 0;
    mid = 0;
    if (r >= 2) top = upper_row[c];
    if (r >= 1) mid = middle_row[c];
    upper_row[c] = pix_t'(mid);
    middle_row[c] = pix_t'(g);
    for (int i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = pix_t'(top);
    win[7] = pix_t'(mid);
    win[8] = pix_t'(g);
    if (r >= 2 || (r == 1 && c >= 1)) begin
      cc = (c == 0) ? w - 1 : c - 1;
      for (int i = 0; i < 9; i++) z[i] = win[i];
      // zero padding at the left and right borders
      if (cc == 0) begin
        z[0] = 0; z[1] = 0; z[2] = 0;
      end
      if (cc == w - 1) begin
        z[6] = 0; z[7] = 0; z[8] = 0;
      end
      gx = (z[2] + 2 * z[5] + z[8]) - (z[0] + 2 * z[3] + z[6]);
      gy = (z[6] + 2 * z[7] + z[8]) - (z[0] + 2 * z[1] + z[2]);
      sq = gx * gx + gy * gy;
      root = 0;
      if (sq >= 65536) root = 255;
      else while ((root + 1) * (root + 1) <= sq) root++;
      results_in_frame++;
      res.edge_value = pix_t'(root);
      res.frame_last = (results_in_frame >= w * h);
      edge_expected.push_back(res);
      if (res.frame_last) begin
        restart_position();
        return;
      end
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  initial begin : result_checker
    edge_result_t want;
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) begin
        results_seen++;
        if (edge_expected.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $error("unexpected result: edge_value %0d frame_last %0b", m_tdata, m_tlast);
        end else begin
          want = edge_expected.pop_front();
          if (want.frame_last) frames_done++;
          if (m_tdata !== want.edge_value) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $error("edge_value: expected %0d, got %0d", want.edge_value, m_tdata);
          end
          if (m_tlast !== want.frame_last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $error("frame_last: expected %0b, got %0b", want.frame_last, m_tlast);
          end
        end
      end
    end
  end

  initial begin : result_receiver
    ready_mode_t mode;
    int unsigned left, phase, hold;
    mode = READY_ALWAYS;
    left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = ready_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end
        left--;
        phase++;
        case (mode)
          READY_ALWAYS:   m_tready <= 1'b1;
          READY_HALF:     m_tready <= 1'($urandom_range(0, 1));
          READY_SPARSE:   m_tready <= ($urandom_range(0, 4) == 0);
          READY_PERIODIC: m_tready <= (phase % 4 == 0);
          default:        m_tready <= 1'b1;
        endcase
      end
    end
  end

  function automatic pix_t rand_chan();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // called at a rising edge; returns at the edge that took the item, or later after an idle gap
  task automatic send_item(input logic kind, input pix_t c0, input pix_t c1, input pix_t c2);
    logic took;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {c2, c1, c0};
    do begin
      @(negedge clk);
      took = s_tready;
      if (took) sobel_predict(kind, c0, c1, c2);
      @(posedge clk);
    end while (!took);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && sender_gaps) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(1'($urandom_range(0, 1)), rand_chan(), rand_chan(), rand_chan());
  endtask

  // w and h are the effective sizes
  task automatic send_frame(input int unsigned w, input int unsigned h);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(KIND_FLUSH, rand_chan(), rand_chan(), rand_chan());
      else send_item(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan());
    end
    // a pixel in the flush region must count as padding
    for (int unsigned i = 0; i <= w; i++) begin
      if ($urandom_range(0, 3) == 0) send_item(KIND_PIXEL, rand_chan(), rand_chan(), rand_chan());
      else send_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (edge_expected.size() != 0) @(posedge clk);
    // items that give no result may still be in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input logic colour);
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_COLOR_MODE, CFG_DATA_W'(colour));
  endtask

  // 640 x 480 colour after reset: results start once the first row and two items of the next are stored
  task automatic test_reset_defaults();
    send_random(660);
    wait_idle();
  endtask

  task automatic test_directed_cases();
    configure(3, 3, 1'b1);
    send_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(KIND_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(KIND_PIXEL, 8'd255, 8'd255, 8'd254);
    send_item(KIND_PIXEL, 8'd1, 8'd0, 8'd0);
    send_item(KIND_FLUSH, 8'd255, 8'd255, 8'd255); // flush inside the image
    send_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(KIND_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(KIND_PIXEL, 8'd128, 8'd64, 8'd2);
    send_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    send_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(KIND_FLUSH, 8'd255, 8'd255, 8'd255);
    send_item(KIND_PIXEL, 8'd17, 8'd34, 8'd51);
    wait_idle();
    // gray mode, the other channels must not matter
    configure(3, 2, 1'b0);
    send_item(KIND_PIXEL, 8'd255, 8'd0, 8'd255);
    send_item(KIND_PIXEL, 8'd0, 8'd255, 8'd255);
    send_item(KIND_PIXEL, 8'd255, 8'd255, 8'd0);
    send_item(KIND_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(KIND_PIXEL, 8'd255, 8'd0, 8'd0);
    send_item(KIND_PIXEL, 8'd0, 8'd255, 8'd0);
    for (int i = 0; i < 4; i++) send_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    wait_idle();
  endtask

  task automatic test_size_extremes();
    configure(0, 0, 1'b1);
    send_frame(1, 1);
    wait_idle();
    configure(1, 65535, 1'b0);
    send_random(40);
    wait_idle();
    // full line store width and a wider setting that clamps; first row only, no result due
    configure(2048, 1, 1'b1);
    send_random(30);
    wait_idle();
    configure(4095, 3, 1'b1);
    send_random(30);
    wait_idle();
  endtask

  task automatic test_register_restart();
    configure(5, 4, 1'b1);
    send_random(12);
    wait_idle();
    write_reg(CFG_UNUSED, 16'hffff);
    send_random(7);
    wait_idle();
    write_reg(CFG_COLOR_MODE, 16'h0000);
    send_frame(5, 4);
    send_frame(5, 4);
    wait_idle();
  endtask

  task automatic test_output_hold_off();
    configure(8, 6, 1'b1);
    sender_gaps = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    send_frame(8, 6);
    sender_gaps = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start, w, h, w_eff, h_eff, frames, order;
    logic colour;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:                   w = 0;
        15, 16, 17, 18:      w = $urandom_range(13, 40);
        19:                  w = $urandom_range(41, 100);
        default:             w = $urandom_range(1, 12);
      endcase
      h = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 6);
      // wide rows get short frames to keep the item count in bounds
      if (w > 40) h = $urandom_range(1, 2);
      colour = 1'($urandom_range(0, 1));
      w_eff = (w == 0) ? 1 : w;
      h_eff = (h == 0) ? 1 : h;
      wait_idle();
      order = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        case ((order + k) % 3)
          0: write_reg(CFG_FRAME_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
          1: write_reg(CFG_FRAME_HEIGHT, 16'(h));
          default: write_reg(CFG_COLOR_MODE, {15'($urandom_range(0, 32767)), colour});
        endcase
      end
      frames = (w > 40) ? 1 : $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        case ($urandom_range(0, 9))
          0:       send_random($urandom_range(1, w_eff * h_eff + w_eff));
          1:       send_random($urandom_range(1, 20));
          default: send_frame(w_eff, h_eff);
        endcase
      end
    end
    wait_idle();
  endtask

  initial begin : test_sequence
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_size_extremes();
    test_register_restart();
    test_output_hold_off();
    test_random_frames();
    if (edge_expected.size() != 0) begin
      error_count++;
      $error("%0d expected results never arrived", edge_expected.size());
    end
    $display("covered %0d items and %0d checked results over %0d complete frames",
             items_sent, results_seen, frames_done);
    $display("reset sizes, small and odd frames, gray and colour, restarts, %0d-cycle hold-off",
             HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("sobel_edge_magnitude_core test passed");
    end else begin
      $display("sobel_edge_magnitude_core test failed");
    end
    $finish;
  end

endmodule
